FILE: sv/fpgs_pkg.sv
// fuzzy pd gain scheduler package: types, domain points, rule tables, membership function
// no dependencies
package fpgs_pkg;

	localparam int CfgIdxW = 3;
	localparam logic [CfgIdxW-1:0] REG_ERR_FS  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_CHG_FS  = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_KP_SPAN = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_KD_SPAN = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_KP_OFF  = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_KD_OFF  = 3'd5;

	localparam logic [14:0] ERR_TOP = 15'd24576;
	localparam logic [14:0] CHG_TOP = 15'd12288;
	localparam logic [14:0] ERR_MUL = 15'd24576;
	localparam logic [14:0] CHG_MUL = 15'd12288;
	localparam logic [14:0] WIDE_W  = 15'd14336;
	// reciprocals of 6 and 42 for scaled dividends below 2^22
	localparam logic [22:0] RCP_NARROW = 23'd5592406;
	localparam logic [22:0] RCP_WIDE   = 23'd6391321;
	localparam int RcpShNarrow = 25;
	localparam int RcpShWide   = 28;
	localparam logic [4:0] SH_ERR = 5'd11;
	localparam logic [4:0] SH_CHG = 5'd12;

	typedef logic signed [16:0] fpgs_pt_t;

	localparam fpgs_pt_t ERR_PTS [7] = '{17'sd0, 17'sd14336, 17'sd16384, 17'sd18432,
		17'sd20480, 17'sd22528, 17'sd24576};
	localparam fpgs_pt_t CHG_PTS [7] = '{-17'sd12288, -17'sd8192, -17'sd4096, 17'sd0,
		17'sd4096, 17'sd8192, 17'sd12288};

	localparam logic [2:0] KP_TAB [7][7] = '{
		'{3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0},
		'{3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1, 3'd1},
		'{3'd1, 3'd1, 3'd1, 3'd2, 3'd3, 3'd3, 3'd3},
		'{3'd2, 3'd2, 3'd3, 3'd3, 3'd3, 3'd4, 3'd4},
		'{3'd3, 3'd3, 3'd4, 3'd4, 3'd4, 3'd5, 3'd5},
		'{3'd4, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6},
		'{3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6, 3'd6}
	};

	localparam logic [2:0] KD_TAB [7][7] = '{
		'{3'd6, 3'd5, 3'd4, 3'd4, 3'd4, 3'd3, 3'd2},
		'{3'd6, 3'd5, 3'd4, 3'd4, 3'd4, 3'd3, 3'd2},
		'{3'd6, 3'd5, 3'd4, 3'd3, 3'd3, 3'd2, 3'd2},
		'{3'd5, 3'd4, 3'd3, 3'd3, 3'd2, 3'd2, 3'd1},
		'{3'd4, 3'd3, 3'd3, 3'd3, 3'd2, 3'd1, 3'd0},
		'{3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd1, 3'd0},
		'{3'd3, 3'd3, 3'd3, 3'd2, 3'd2, 3'd1, 3'd0}
	};

	typedef struct packed {
		logic [2:0]  lo;
		logic [14:0] n0;
		logic [14:0] n1;
		logic [14:0] w;
	} fpgs_fuzz_t;

	typedef struct packed {
		logic [14:0] err_fs;
		logic [14:0] chg_fs;
		logic [15:0] kp_span;
		logic [15:0] kd_span;
		logic [15:0] kp_off;
		logic [15:0] kd_off;
	} fpgs_cfg_t;

	typedef struct packed {
		logic load_in;
		logic prep;
		logic clamp;
		logic fuzz;
		logic row;
		logic mul1;
		logic mul2;
		logic div2;
		logic load_out;
	} fpgs_cmd_t;

	typedef struct packed {
		logic div_done;
	} fpgs_sts_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_PREP, ST_WAIT1, ST_CLAMP, ST_FUZZ, ST_ROW,
		ST_MUL1, ST_MUL2, ST_DIV2, ST_DONE
	} fpgs_state_t;

	function automatic fpgs_fuzz_t fuzzify(input fpgs_pt_t v, input fpgs_pt_t pts [7]);
		fpgs_fuzz_t r;
		fpgs_pt_t   a;
		fpgs_pt_t   b;
		r.lo = 3'd0;
		r.n0 = 15'd1;
		r.n1 = 15'd0;
		r.w  = 15'd1;
		if (v <= pts[0]) begin
			r.lo = 3'd0;
		end else if (v >= pts[6]) begin
			r.lo = 3'd5;
			r.n0 = 15'd0;
			r.n1 = 15'd1;
		end else begin
			for (int i = 0; i < 6; i++) begin
				if (pts[i] < v && v <= pts[i+1]) begin
					a = pts[i+1] - v;
					b = v - pts[i];
					r.lo = 3'(i);
					r.n0 = a[14:0];
					r.n1 = b[14:0];
					a = pts[i+1] - pts[i];
					r.w  = a[14:0];
				end
			end
		end
		return r;
	endfunction

endpackage

FILE: sv/fpgs_div.sv
// serial restoring divider, one quotient bit per cycle, 32-bit dividend by 16-bit divisor
// no dependencies
module fpgs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [15:0] divisor,
	output logic [31:0] quotient,
	output logic        done
);

	logic [31:0] dq_q;
	logic [15:0] rem_q;
	logic [15:0] dvs_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [16:0] trial;
	logic        fits;
	logic [16:0] diff;

	assign trial = {rem_q, dq_q[31]};
	assign fits  = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd31) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[15:0] : trial[15:0];
			dq_q  <= {dq_q[30:0], fits};
		end
	end

	assign quotient = dq_q;
	assign done     = done_q;

endmodule

FILE: sv/fpgs_datapath.sv
// datapath: error mapping, membership, rule weighting, gain scaling, output registers
// depends on fpgs_pkg and fpgs_div
module fpgs_datapath import fpgs_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  fpgs_cmd_t   cmd,
	output fpgs_sts_t   sts,
	input  fpgs_cfg_t   cfg,
	input  logic [15:0] track_error,
	output logic [16:0] kp_gain,
	output logic [16:0] kd_gain
);

	logic signed [15:0] e_q;
	logic signed [15:0] prev_q;
	logic               neg_q;
	logic               dneg_q;
	logic               flip_q;
	logic [14:0]        em_q;
	fpgs_pt_t           cm_q;
	fpgs_fuzz_t         fe_q;
	fpgs_fuzz_t         fc_q;
	logic [15:0]        rp0_q, rp1_q, rd0_q, rd1_q;
	logic [28:0]        nkp_q, nkd_q;
	logic [44:0]        pkp_q, pkd_q;
	logic [44:0]        qpk_q, qpd_q;
	logic [16:0]        kp_q, kd_q;

	logic [16:0] e_ext, e_neg, diff, d_neg;
	logic [15:0] e_mag, d_mag;
	logic [31:0] num_e, num_c;
	logic [15:0] efs, cfs;
	logic        flip;
	logic [31:0] qa, qb;
	logic        done_a, done_b;
	logic        start;
	logic [14:0] em;
	logic [13:0] cm_mag;
	fpgs_pt_t    cm_s, cm;
	fpgs_fuzz_t  fe, fc;
	logic [2:0]  e1, c1;
	logic [31:0] nkp, nkd;
	logic [4:0]  sh;
	logic [44:0] sa, sb;
	logic        wide;
	logic [22:0] rcp;
	logic [15:0] gkp, gkd;

	// input mapping numerators
	assign e_ext = {e_q[15], e_q};
	assign e_neg = 17'd0 - e_ext;
	assign e_mag = e_q[15] ? e_neg[15:0] : e_ext[15:0];
	assign diff  = e_ext - {prev_q[15], prev_q};
	assign d_neg = 17'd0 - diff;
	assign d_mag = diff[16] ? d_neg[15:0] : diff[15:0];
	assign num_e = 32'(e_mag) * 32'(ERR_MUL);
	assign num_c = 32'(d_mag) * 32'(CHG_MUL);
	assign efs   = (cfg.err_fs == '0) ? 16'd1 : {1'b0, cfg.err_fs};
	assign cfs   = (cfg.chg_fs == '0) ? 16'd1 : {1'b0, cfg.chg_fs};
	assign flip  = (e_q > 16'sd0 && prev_q < 16'sd0) || (e_q < 16'sd0 && prev_q > 16'sd0);

	// gain scaling shift and reciprocal
	assign sh   = ((fe_q.w != 15'd1) ? SH_ERR : 5'd0) + ((fc_q.w != 15'd1) ? SH_CHG : 5'd0);
	assign wide = (fe_q.w == WIDE_W);
	assign rcp  = wide ? RCP_WIDE : RCP_NARROW;
	assign sa   = pkp_q >> sh;
	assign sb   = pkd_q >> sh;
	assign gkp  = wide ? qpk_q[RcpShWide +: 16] : qpk_q[RcpShNarrow +: 16];
	assign gkd  = wide ? qpd_q[RcpShWide +: 16] : qpd_q[RcpShNarrow +: 16];

	assign start = cmd.prep;

	fpgs_div u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dividend (num_e),
		.divisor  (efs),
		.quotient (qa),
		.done     (done_a)
	);

	fpgs_div u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.dividend (num_c),
		.divisor  (cfs),
		.quotient (qb),
		.done     (done_b)
	);

	assign sts.div_done = done_a & done_b;

	// clamp and sign handling
	assign em     = (qa > 32'(ERR_TOP)) ? ERR_TOP : qa[14:0];
	assign cm_mag = (qb > 32'(CHG_TOP)) ? CHG_TOP[13:0] : qb[13:0];
	assign cm_s   = (dneg_q ^ neg_q) ? (17'sd0 - fpgs_pt_t'({3'b0, cm_mag}))
		: fpgs_pt_t'({3'b0, cm_mag});
	assign cm     = flip_q ? fpgs_pt_t'({2'b0, CHG_TOP}) : cm_s;

	assign fe = fuzzify(fpgs_pt_t'({2'b0, em_q}), ERR_PTS);
	assign fc = fuzzify(cm_q, CHG_PTS);

	assign e1 = fe_q.lo + 3'd1;
	assign c1 = fc_q.lo + 3'd1;

	assign nkp = 32'(fe_q.n0) * 32'(rp0_q) + 32'(fe_q.n1) * 32'(rp1_q);
	assign nkd = 32'(fe_q.n0) * 32'(rd0_q) + 32'(fe_q.n1) * 32'(rd1_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q <= '0;
		end else if (cmd.prep) begin
			prev_q <= e_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			e_q <= track_error;
		end
		if (cmd.prep) begin
			neg_q  <= e_q[15];
			dneg_q <= diff[16];
			flip_q <= flip;
		end
		if (cmd.clamp) begin
			em_q <= em;
			cm_q <= cm;
		end
		if (cmd.fuzz) begin
			fe_q <= fe;
			fc_q <= fc;
		end
		if (cmd.row) begin
			rp0_q <= 16'(fc_q.n0) * 16'(KP_TAB[fe_q.lo][fc_q.lo])
				+ 16'(fc_q.n1) * 16'(KP_TAB[fe_q.lo][c1]);
			rp1_q <= 16'(fc_q.n0) * 16'(KP_TAB[e1][fc_q.lo])
				+ 16'(fc_q.n1) * 16'(KP_TAB[e1][c1]);
			rd0_q <= 16'(fc_q.n0) * 16'(KD_TAB[fe_q.lo][fc_q.lo])
				+ 16'(fc_q.n1) * 16'(KD_TAB[fe_q.lo][c1]);
			rd1_q <= 16'(fc_q.n0) * 16'(KD_TAB[e1][fc_q.lo])
				+ 16'(fc_q.n1) * 16'(KD_TAB[e1][c1]);
		end
		if (cmd.mul1) begin
			nkp_q <= nkp[28:0];
			nkd_q <= nkd[28:0];
		end
		if (cmd.mul2) begin
			pkp_q <= 45'(nkp_q) * 45'(cfg.kp_span);
			pkd_q <= 45'(nkd_q) * 45'(cfg.kd_span);
		end
		if (cmd.div2) begin
			qpk_q <= 45'(sa[21:0]) * 45'(rcp);
			qpd_q <= 45'(sb[21:0]) * 45'(rcp);
		end
		if (cmd.load_out) begin
			kp_q <= 17'(cfg.kp_off) + 17'(gkp);
			kd_q <= 17'(cfg.kd_off) + 17'(gkd);
		end
	end

	assign kp_gain = kp_q;
	assign kd_gain = kd_q;

endmodule

FILE: sv/fpgs_ctrl.sv
// controller state machine: sequences the datapath and runs both handshakes
// depends on fpgs_pkg
module fpgs_ctrl import fpgs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	input  fpgs_sts_t sts,
	output fpgs_cmd_t cmd
);

	fpgs_state_t state_q, state_nx;
	logic        out_valid_q;
	logic        out_free;

	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid) state_nx = ST_PREP;
			ST_PREP:  state_nx = ST_WAIT1;
			ST_WAIT1: if (sts.div_done) state_nx = ST_CLAMP;
			ST_CLAMP: state_nx = ST_FUZZ;
			ST_FUZZ:  state_nx = ST_ROW;
			ST_ROW:   state_nx = ST_MUL1;
			ST_MUL1:  state_nx = ST_MUL2;
			ST_MUL2:  state_nx = ST_DIV2;
			ST_DIV2:  state_nx = ST_DONE;
			ST_DONE:  if (out_free) state_nx = ST_IDLE;
			default:  state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_PREP:  cmd.prep  = 1'b1;
			ST_CLAMP: cmd.clamp = 1'b1;
			ST_FUZZ:  cmd.fuzz  = 1'b1;
			ST_ROW:   cmd.row   = 1'b1;
			ST_MUL1:  cmd.mul1  = 1'b1;
			ST_MUL2:  cmd.mul2  = 1'b1;
			ST_DIV2:  cmd.div2  = 1'b1;
			ST_DONE:  cmd.load_out = out_free;
			default:  cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef SYNTH
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result register overwritten");
	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_PREP))
		else $error("accepted beat not started");
	a_wait_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WAIT1 && !sts.div_done) |=> (state_q == ST_WAIT1))
		else $error("left divide wait early");
	a_out_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |=> out_valid_q)
		else $error("loaded result not offered");
`endif

endmodule

FILE: sv/fuzzy_pd_gain_scheduler.sv
// fuzzy pd gain scheduler top: configuration registers, controller and datapath
// depends on fpgs_pkg, fpgs_ctrl, fpgs_datapath
// the 32-step serial divides of the error and change mapping take most of the time from
// input beat to result offered
// one beat is worked on at a time; the result register lets the next beat enter while the last result waits
// reset: previous error cleared to zero, configuration to its default values
module fuzzy_pd_gain_scheduler import fpgs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic signed [15:0] track_error,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [16:0]        kp_gain,
	output logic [16:0]        kd_gain,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [15:0]        cfg_data
);

	fpgs_cfg_t cfg_q;
	fpgs_cmd_t cmd;
	fpgs_sts_t sts;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.err_fs  <= 15'd1920;
			cfg_q.chg_fs  <= 15'd800;
			cfg_q.kp_span <= 16'd512;
			cfg_q.kd_span <= 16'd2560;
			cfg_q.kp_off  <= 16'd2048;
			cfg_q.kd_off  <= 16'd4096;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ERR_FS:  cfg_q.err_fs  <= cfg_data[14:0];
				REG_CHG_FS:  cfg_q.chg_fs  <= cfg_data[14:0];
				REG_KP_SPAN: cfg_q.kp_span <= cfg_data;
				REG_KD_SPAN: cfg_q.kd_span <= cfg_data;
				REG_KP_OFF:  cfg_q.kp_off  <= cfg_data;
				REG_KD_OFF:  cfg_q.kd_off  <= cfg_data;
				default:     cfg_q <= cfg_q;
			endcase
		end
	end

	fpgs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	fpgs_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.cfg         (cfg_q),
		.track_error (track_error),
		.kp_gain     (kp_gain),
		.kd_gain     (kd_gain)
	);

endmodule

FILE: sim/fuzzy_pd_gain_scheduler_tb.sv
// testbench for fuzzy_pd_gain_scheduler: random and directed tracking errors with
// randomized handshakes, checked against an in-bench gain predictor
// depends on fpgs_pkg and the fuzzy_pd_gain_scheduler rtl
`timescale 1ns / 100ps

module fuzzy_pd_gain_scheduler_tb;
	import fpgs_pkg::*;

	localparam int WatchdogLimit = 20000;
	localparam int DrainCycles = 200;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	logic signed [15:0] track_error;
	logic               out_valid;
	logic               out_ready;
	logic [16:0]        kp_gain;
	logic [16:0]        kd_gain;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [15:0]        cfg_data;

	typedef struct {
		logic [16:0] kp;
		logic [16:0] kd;
	} gain_pair_t;

	gain_pair_t  gain_queue[$];
	fpgs_cfg_t   model_cfg;
	logic signed [15:0] model_prev_err;
	int          fail_count;
	int          idle_cycles;
	int          stall_pct;
	bit          out_stall_en;

	fuzzy_pd_gain_scheduler u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .track_error(track_error),
		.out_valid(out_valid), .out_ready(out_ready),
		.kp_gain(kp_gain), .kd_gain(kd_gain),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void pick_cells(input longint v, input longint pts[7], output int lo,
			output longint n0, output longint n1, output longint w);
		lo = 0; n0 = 1; n1 = 0; w = 1;
		if (v >= pts[6]) begin
			lo = 5; n0 = 0; n1 = 1;
		end else if (v > pts[0]) begin
			for (int i = 0; i < 6; i++) begin
				if (pts[i] < v && v <= pts[i+1]) begin
					lo = i; n0 = pts[i+1] - v; n1 = v - pts[i]; w = pts[i+1] - pts[i];
				end
			end
		end
	endfunction

	function automatic gain_pair_t predict_gains(input logic signed [15:0] err);
		longint ep[7] = '{0, 14336, 16384, 18432, 20480, 22528, 24576};
		longint cp[7] = '{-12288, -8192, -4096, 0, 4096, 8192, 12288};
		int kpt[7][7] = '{'{0,0,0,0,0,0,0}, '{1,1,1,1,1,1,1}, '{1,1,1,2,3,3,3},
			'{2,2,3,3,3,4,4}, '{3,3,4,4,4,5,5}, '{4,5,5,5,5,5,6}, '{6,6,6,6,6,6,6}};
		int kdt[7][7] = '{'{6,5,4,4,4,3,2}, '{6,5,4,4,4,3,2}, '{6,5,4,3,3,2,2},
			'{5,4,3,3,2,2,1}, '{4,3,3,3,2,1,0}, '{3,3,3,2,2,1,0}, '{3,3,3,2,2,1,0}};
		longint e, d, efs, cfs, mag, em, cm, en[2], cn[2], ew, cw, skp, skd, den;
		int ei, ci;
		gain_pair_t r;
		e = err;
		d = e - longint'(model_prev_err);
		efs = (model_cfg.err_fs == 0) ? 1 : model_cfg.err_fs;
		cfs = (model_cfg.chg_fs == 0) ? 1 : model_cfg.chg_fs;
		mag = (e < 0) ? -e : e;
		em = mag * 6 * 4096 / efs;
		cm = d * 3 * 4096 / cfs;
		if (em > 24576) em = 24576;
		if (cm > 12288) cm = 12288;
		if (cm < -12288) cm = -12288;
		if (e < 0) cm = -cm;
		if ((e > 0 && model_prev_err < 0) || (e < 0 && model_prev_err > 0)) cm = 12288;
		pick_cells(em, ep, ei, en[0], en[1], ew);
		pick_cells(cm, cp, ci, cn[0], cn[1], cw);
		skp = 0; skd = 0;
		for (int a = 0; a < 2; a++)
			for (int b = 0; b < 2; b++) begin
				skp += en[a] * cn[b] * kpt[ei+a][ci+b];
				skd += en[a] * cn[b] * kdt[ei+a][ci+b];
			end
		den = ew * cw * 6;
		r.kp = 17'(longint'(model_cfg.kp_off) + skp * model_cfg.kp_span / den);
		r.kd = 17'(longint'(model_cfg.kd_off) + skd * model_cfg.kd_span / den);
		model_prev_err = err;
		return r;
	endfunction

	task automatic random_gap();
		if (stall_pct > 0) begin
			while ($urandom_range(99, 0) < stall_pct) begin
				@(posedge clk);
			end
		end
	endtask

	task automatic send_error(input logic signed [15:0] err);
		random_gap();
		in_valid <= 1'b1;
		track_error <= err;
		gain_queue.push_back(predict_gains(err));
		do @(posedge clk); while (!in_ready);
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
		case (idx)
			REG_ERR_FS:  model_cfg.err_fs = val[14:0];
			REG_CHG_FS:  model_cfg.chg_fs = val[14:0];
			REG_KP_SPAN: model_cfg.kp_span = val;
			REG_KD_SPAN: model_cfg.kd_span = val;
			REG_KP_OFF:  model_cfg.kp_off = val;
			REG_KD_OFF:  model_cfg.kd_off = val;
			default: ;
		endcase
	endtask

	task automatic wait_drain();
		while (gain_queue.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_all(input logic [15:0] efs, input logic [15:0] cfs,
			input logic [15:0] kps, input logic [15:0] kds, input logic [15:0] kpo,
			input logic [15:0] kdo);
		wait_drain();
		write_reg(REG_ERR_FS, efs);
		write_reg(REG_CHG_FS, cfs);
		write_reg(REG_KP_SPAN, kps);
		write_reg(REG_KD_SPAN, kds);
		write_reg(REG_KP_OFF, kpo);
		write_reg(REG_KD_OFF, kdo);
	endtask

	task automatic test_directed();
		logic signed [15:0] vals[] = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd0, 16'sd1920,
			16'sd1600, -16'sd1600, 16'sd160, 16'sd480, 16'sd1440, 16'sd1120, -16'sd1, 16'sd1,
			16'sd0, -16'sd800, -16'sd2000, 16'sd5, 16'sd2, 16'sd1000, 16'sd1280};
		foreach (vals[i]) send_error(vals[i]);
	endtask

	task automatic test_bad_index();
		wait_drain();
		write_reg(3'd6, 16'hFFFF);
		write_reg(3'd7, 16'h0000);
		send_error(16'sd700);
		send_error(-16'sd300);
	endtask

	task automatic test_random(input int count, input int maxmag);
		logic signed [15:0] v;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(3, 0))
				0: v = 16'($urandom);
				1: v = 16'(model_prev_err + $signed(16'($urandom_range(400, 0))) - 200);
				default: v = 16'($signed($urandom_range(2 * maxmag, 0)) - maxmag);
			endcase
			send_error(v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= !out_stall_en || ($urandom_range(99, 0) >= 29);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (gain_queue.size() == 0) begin
				$display("%0t: unexpected result kp %0d kd %0d", $time, kp_gain, kd_gain);
				fail_count++;
			end else begin
				if (kp_gain !== gain_queue[0].kp || kd_gain !== gain_queue[0].kd) begin
					$display("%0t: mismatch expected kp %0d kd %0d actual kp %0d kd %0d", $time,
						gain_queue[0].kp, gain_queue[0].kd, kp_gain, kd_gain);
					fail_count++;
				end
				void'(gain_queue.pop_front());
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WatchdogLimit) begin
			$display("fuzzy_pd_gain_scheduler_tb failed");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		track_error = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		fail_count = 0;
		idle_cycles = 0;
		stall_pct = 29;
		out_stall_en = 1'b1;
		model_cfg = '{15'd1920, 15'd800, 16'd512, 16'd2560, 16'd2048, 16'd4096};
		model_prev_err = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(400, 2500);
		stall_pct = 0;
		out_stall_en = 1'b0;
		test_random(150, 2500);
		stall_pct = 29;
		out_stall_en = 1'b1;
		write_all(16'd1, 16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		test_random(150, 32768);
		write_all(16'h7FFF, 16'h7FFF, 16'd0, 16'd0, 16'd0, 16'd0);
		test_random(150, 32768);
		write_all(16'h8000, 16'h0000, 16'd1234, 16'd40000, 16'd300, 16'd9);
		test_directed();
		test_random(100, 100);
		test_bad_index();
		for (int k = 0; k < 3; k++) begin
			write_all(16'($urandom_range(3000, 1)), 16'($urandom_range(3000, 1)),
				16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
			test_random(150, 4000);
		end
		wait_drain();
		if (fail_count == 0)
			$display("fuzzy_pd_gain_scheduler_tb passed");
		else
			$display("fuzzy_pd_gain_scheduler_tb failed");
		$finish;
	end

endmodule
